/* rtl/qsf_pkg.sv */
package qsf_pkg;

  localparam int MAX_RUN_LENGTH_DEF = 16;
  localparam int CNT_W = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    REG_START_SIL = 2'd0,
    REG_PREAMBLE  = 2'd1,
    REG_SYNC_EN   = 2'd2,
    REG_END_SIL   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    cnt_t start_sil;
    cnt_t preamble;
    logic sync_en;
    cnt_t end_sil;
  } qsf_cfg_t;

  // one frame segment plan per accepted word that produces symbols
  typedef struct packed {
    cnt_t       start_sil;
    cnt_t       preamble;
    logic       sync_en;
    logic       present;
    logic [7:0] data_byte;
    cnt_t       end_sil;
  } qsf_desc_t;

endpackage

/* rtl/qpsk_symbol_framer.sv */
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | data_byte, byte_present, frame_first, frame_last
// out     | output    | out_valid / out_ready  | symbol_value, silent, run_last
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one symbol per cycle from a single sequencer into the output register while not stalled
// a word emits start_sil + preamble + 4*sync + 4*byte + end_sil symbols (runs capped), a plain byte 4
// accepted words wait in a two-entry queue before the sequencer registers their first symbol
// in_ready drops only when the queue is full; out_ready low holds the output register
// reset clears the configuration to zero and empties the queue and sequencer
module qpsk_symbol_framer import qsf_pkg::*; #(
  parameter int MAX_RUN_LENGTH = MAX_RUN_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_frame_first,
  input  logic       in_frame_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_symbol_value,
  output logic       out_silent,
  output logic       out_run_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  qsf_cfg_t  cfg_r;
  logic      q_ready;
  logic      q_push;
  qsf_desc_t q_push_data;
  logic      q_pop;
  logic      q_valid;
  qsf_desc_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_SIL: cfg_r.start_sil <= cfg_data;
        REG_PREAMBLE:  cfg_r.preamble  <= cfg_data;
        REG_SYNC_EN:   cfg_r.sync_en   <= cfg_data[0];
        REG_END_SIL:   cfg_r.end_sil   <= cfg_data;
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  qsf_front #(
    .MAX_RUN_LENGTH(MAX_RUN_LENGTH)
  ) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .in_frame_first  (in_frame_first),
    .in_frame_last   (in_frame_last),
    .cfg             (cfg_r),
    .q_ready         (q_ready),
    .q_push          (q_push),
    .q_push_data     (q_push_data)
  );

  qsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  qsf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol_value (out_symbol_value),
    .out_silent       (out_silent),
    .out_run_last     (out_run_last)
  );

endmodule

/* rtl/qsf_front.sv */
module qsf_front import qsf_pkg::*; #(
  parameter int MAX_RUN_LENGTH = MAX_RUN_LENGTH_DEF
) (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_frame_first,
  input  logic       in_frame_last,
  input  qsf_cfg_t   cfg,
  input  logic       q_ready,
  output logic       q_push,
  output qsf_desc_t  q_push_data
);

  localparam cnt_t CAP = CNT_W'(MAX_RUN_LENGTH);

  function automatic cnt_t cap_len(cnt_t v);
    return (v > CAP) ? CAP : v;
  endfunction

  qsf_desc_t desc;
  logic      has_symbols;

  always_comb begin
    desc.start_sil = in_frame_first ? cap_len(cfg.start_sil) : '0;
    desc.preamble  = in_frame_first ? cap_len(cfg.preamble) : '0;
    desc.sync_en   = in_frame_first & cfg.sync_en;
    desc.present   = in_byte_present;
    desc.data_byte = in_data_byte;
    desc.end_sil   = in_frame_last ? cap_len(cfg.end_sil) : '0;
  end

  // words that produce nothing never enter the queue
  assign has_symbols = (desc.start_sil != '0) || (desc.preamble != '0) || desc.sync_en ||
                       desc.present || (desc.end_sil != '0);

  assign in_ready    = q_ready;
  assign q_push      = in_valid & q_ready & has_symbols;
  assign q_push_data = desc;

endmodule

/* rtl/qsf_queue.sv */
module qsf_queue import qsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  qsf_desc_t push_data,
  output logic      ready,
  input  logic      pop,
  output logic      head_valid,
  output qsf_desc_t head
);

  qsf_desc_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign ready      = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ptr_inc(wptr_r) : wptr_r;
    rptr_nxt = pop ? ptr_inc(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != QCNT_W'(QUEUE_DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue pop while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + QCNT_W'(1)))
    else $error("queue count did not advance on push");

endmodule

/* rtl/qsf_back.sv */
module qsf_back import qsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  qsf_desc_t  q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_symbol_value,
  output logic       out_silent,
  output logic       out_run_last
);

  typedef enum logic [2:0] {
    PH_SSIL = 3'd0,
    PH_PRE  = 3'd1,
    PH_SYNC = 3'd2,
    PH_DATA = 3'd3,
    PH_ESIL = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  function automatic cnt_t seg_len(qsf_desc_t d, logic [2:0] k);
    cnt_t r;
    case (phase_t'(k))
      PH_SSIL: r = d.start_sil;
      PH_PRE:  r = d.preamble;
      PH_SYNC: r = d.sync_en ? CNT_W'(4) : '0;
      PH_DATA: r = d.present ? CNT_W'(4) : '0;
      PH_ESIL: r = d.end_sil;
      default: r = '0;
    endcase
    return r;
  endfunction

  // lowest non-empty segment at or after start
  function automatic phase_t first_from(qsf_desc_t d, logic [2:0] start);
    phase_t r;
    r = PH_DONE;
    for (int k = 4; k >= 0; k--) begin
      if (3'(k) >= start && seg_len(d, 3'(k)) != '0) begin
        r = phase_t'(3'(k));
      end
    end
    return r;
  endfunction

  logic      busy_r, busy_nxt;
  phase_t    phase_r, phase_nxt;
  cnt_t      idx_r, idx_nxt;
  qsf_desc_t work_r, work_nxt;
  logic       out_valid_r;
  logic [1:0] out_symbol_value_r;
  logic       out_silent_r;
  logic       out_run_last_r;

  qsf_desc_t  cur_d;
  phase_t     cur_ph;
  phase_t     nxt_ph;
  cnt_t       cur_idx;
  logic       emit;
  logic       seg_end;
  logic       run_last;
  logic [1:0] sym;
  logic       sil;

  always_comb begin
    // an idle sequencer starts straight from the queue head, no bubble
    cur_d   = busy_r ? work_r : q_head;
    cur_ph  = busy_r ? phase_r : first_from(q_head, 3'd0);
    cur_idx = busy_r ? idx_r : '0;
    emit    = (busy_r || q_valid) && (!out_valid_r || out_ready);
    q_pop   = emit && !busy_r;

    seg_end  = (cur_idx == seg_len(cur_d, 3'(cur_ph)) - CNT_W'(1));
    nxt_ph   = first_from(cur_d, 3'(cur_ph) + 3'd1);
    run_last = seg_end && (nxt_ph == PH_DONE);

    sym = 2'b00;
    sil = 1'b0;
    case (cur_ph)
      PH_SSIL: sil = 1'b1;
      PH_PRE:  sym = 2'b00;
      PH_SYNC: sym = cur_idx[1:0];
      PH_DATA: begin
        case (cur_idx[1:0])
          2'd0:    sym = cur_d.data_byte[7:6];
          2'd1:    sym = cur_d.data_byte[5:4];
          2'd2:    sym = cur_d.data_byte[3:2];
          default: sym = cur_d.data_byte[1:0];
        endcase
      end
      PH_ESIL: sil = 1'b1;
      default: sil = 1'b0;
    endcase

    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    work_nxt  = work_r;
    if (emit) begin
      work_nxt = cur_d;
      if (run_last) begin
        busy_nxt  = 1'b0;
        phase_nxt = PH_DONE;
        idx_nxt   = '0;
      end else if (seg_end) begin
        busy_nxt  = 1'b1;
        phase_nxt = nxt_ph;
        idx_nxt   = '0;
      end else begin
        busy_nxt  = 1'b1;
        phase_nxt = cur_ph;
        idx_nxt   = cur_idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r             <= 1'b0;
      phase_r            <= PH_DONE;
      idx_r              <= '0;
      work_r             <= '0;
      out_valid_r        <= 1'b0;
      out_symbol_value_r <= 2'b00;
      out_silent_r       <= 1'b0;
      out_run_last_r     <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      work_r  <= work_nxt;
      if (emit) begin
        out_valid_r        <= 1'b1;
        out_symbol_value_r <= sym;
        out_silent_r       <= sil;
        out_run_last_r     <= run_last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol_value = out_symbol_value_r;
  assign out_silent       = out_silent_r;
  assign out_run_last     = out_run_last_r;

  a_silence_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_silent_r) |-> (out_symbol_value_r == 2'b00))
    else $error("silence word carries a symbol value");

  a_busy_has_phase: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (phase_r != PH_DONE))
    else $error("sequencer busy with no active segment");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!busy_r && q_valid))
    else $error("queue popped while a frame plan is in progress");

  a_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && run_last) |=> !busy_r)
    else $error("sequencer still busy after last word of a run");

endmodule
